FILE: rtl/pcsp_pkg.sv
// shared constants, types and helpers for the pixel command stream parser
package pcsp_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned CANVAS_W = 33;
	localparam int unsigned OUT_W    = 2 * VAL_W;

	localparam logic [CANVAS_W-1:0] CANVAS_RESET   = 33'd262144;
	localparam int unsigned          ROW_STRIDE_DEF = 512;

	// characters of the command text
	localparam logic [DATA_W-1:0] CH_NL = 8'h0A;
	localparam logic [DATA_W-1:0] CH_SP = 8'h20;
	localparam logic [DATA_W-1:0] CH_H  = 8'h48;
	localparam logic [DATA_W-1:0] CH_S  = 8'h53;
	localparam logic [DATA_W-1:0] CH_P  = 8'h50;
	localparam logic [DATA_W-1:0] CH_0  = 8'h30;
	localparam logic [DATA_W-1:0] CH_9  = 8'h39;
	localparam logic [DATA_W-1:0] CH_LA = 8'h61;
	localparam logic [DATA_W-1:0] CH_LF = 8'h66;
	localparam logic [DATA_W-1:0] CH_UA = 8'h41;
	localparam logic [DATA_W-1:0] CH_UF = 8'h46;
	localparam logic [DATA_W-1:0] HEX_TEN = 8'd10;

	// skip lengths after a command byte
	localparam logic [2:0] SKIP_HS  = 3'd4;
	localparam logic [2:0] SKIP_P   = 3'd2;
	localparam logic [2:0] SKIP_ONE = 3'd1;

	// one digit step of a field accumulator
	typedef struct packed {
		logic             is_digit;
		logic [3:0]       digit;
		logic             ovf;
		logic [VAL_W-1:0] value;
	} step_t;

	function automatic logic [VAL_W-1:0] swap_bytes(input logic [VAL_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

FILE: rtl/pcsp_digit_step.sv
// digit decode and one accumulate step (decimal or hex) with overflow detect
module pcsp_digit_step (
	input  logic [pcsp_pkg::VAL_W-1:0]  acc,
	input  logic [pcsp_pkg::DATA_W-1:0] data,
	input  logic                        hex,
	output pcsp_pkg::step_t             step
);

	logic [pcsp_pkg::DATA_W-1:0]  off;
	logic [pcsp_pkg::VAL_W+3:0]   dec_v;

	always_comb begin
		step = '0;
		off  = '0;
		if (data >= pcsp_pkg::CH_0 && data <= pcsp_pkg::CH_9) begin
			step.is_digit = 1'b1;
			off = data - pcsp_pkg::CH_0;
		end else if (hex && data >= pcsp_pkg::CH_LA && data <= pcsp_pkg::CH_LF) begin
			step.is_digit = 1'b1;
			off = data - pcsp_pkg::CH_LA + pcsp_pkg::HEX_TEN;
		end else if (hex && data >= pcsp_pkg::CH_UA && data <= pcsp_pkg::CH_UF) begin
			step.is_digit = 1'b1;
			off = data - pcsp_pkg::CH_UA + pcsp_pkg::HEX_TEN;
		end
		step.digit = off[3:0];

		// acc * 10 + d as shift-and-add
		dec_v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, off[3:0]};

		if (hex) begin
			step.ovf   = |acc[31:28];
			step.value = {acc[27:0], off[3:0]};
		end else begin
			step.ovf   = |dec_v[35:32];
			step.value = dec_v[31:0];
		end
	end

endmodule

FILE: rtl/pixel_command_stream_parser.sv
// top level: byte-wide text command parser producing pixel writes
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    data_byte (8 bits)
//  m_axis    out  m_axis_tvalid/m_axis_tready    pixel_index, pixel_color (64 bits)
//  cfg       in   cfg_wr_en                      canvas_pixels (33 bits)
//
//  one byte per cycle while s_axis_tready is high: each accepted byte updates the parse state
//  the critical path is the x + y*stride add and canvas compare, kept narrow
//  by accumulating y*stride as the y digits arrive
//  a result sits in an output register backed by one skid entry; input
//  stalls only while both hold a result that has not been taken
//  arst_n clears the parse state, the canvas size (to 262144) and both result slots
module pixel_command_stream_parser #(
	parameter int unsigned ROW_STRIDE = pcsp_pkg::ROW_STRIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command text: [7:0] data_byte
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [pcsp_pkg::DATA_W-1:0]    s_axis_tdata,
	// pixel writes: [31:0] pixel_index, [63:32] pixel_color
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [pcsp_pkg::OUT_W-1:0]     m_axis_tdata,
	// canvas_pixels register
	input  logic                           cfg_wr_en,
	input  logic [pcsp_pkg::CANVAS_W-1:0]  cfg_wr_data
);

	// y * stride fits in 32 bits plus the bits of the stride
	localparam int unsigned YS_W  = pcsp_pkg::VAL_W + $clog2(ROW_STRIDE + 1);
	localparam int unsigned IDX_W = YS_W + 1;
	localparam logic [YS_W-1:0] STRIDE_V = YS_W'(ROW_STRIDE);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP,
		PH_DISCARD,
		PH_PREFIX,
		PH_X,
		PH_Y,
		PH_COLOR
	} phase_t;

	phase_t phase_q, phase_n;
	logic [2:0] skip_q, skip_n, skip_dec;
	logic [pcsp_pkg::VAL_W-1:0] x_q, x_n, y_q, y_n, color_q, color_n;
	logic [YS_W-1:0] ys_q, ys_n, ys_step, ds;
	logic [YS_W+2:0] ys_wide;
	logic fld_has_q, fld_has_n, fld_stop_q, fld_stop_n, fld_ovf_q, fld_ovf_n;
	logic fld_upd, fld_good;
	logic [pcsp_pkg::CANVAS_W-1:0] canvas_q;
	logic [IDX_W-1:0] idx_sum, canvas_ext;

	logic [pcsp_pkg::VAL_W-1:0] step_acc;
	pcsp_pkg::step_t step;

	logic in_fire, emit, push, pop;
	logic out_valid_q, skid_valid_q;
	logic [pcsp_pkg::OUT_W-1:0] out_data_q, skid_data_q, result;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	// digit unit, fed with the accumulator of the field in progress
	always_comb begin
		unique case (phase_q)
			PH_Y:     step_acc = y_q;
			PH_COLOR: step_acc = color_q;
			default:  step_acc = x_q;
		endcase
	end

	pcsp_digit_step u_step (
		.acc  (step_acc),
		.data (s_axis_tdata),
		.hex  (phase_q == PH_COLOR),
		.step (step)
	);

	// running y*stride: ys*10 + digit*stride
	assign ds      = {{(YS_W-4){1'b0}}, step.digit} * STRIDE_V;
	assign ys_wide = {ys_q, 3'b000} + {2'b00, ys_q, 1'b0} + {3'b000, ds};
	assign ys_step = ys_wide[YS_W-1:0];

	// exact index, never wraps
	assign idx_sum    = {{(IDX_W-pcsp_pkg::VAL_W){1'b0}}, x_q} + {1'b0, ys_q};
	assign canvas_ext = {{(IDX_W-pcsp_pkg::CANVAS_W){1'b0}}, canvas_q};

	assign fld_good = fld_has_q && !fld_ovf_q;
	assign skip_dec = (skip_q != 3'd0) ? skip_q - 3'd1 : 3'd0;

	// field bookkeeping for a byte that does not end the field (newline, or space in x and y)
	always_comb begin
		fld_stop_n = fld_stop_q;
		fld_has_n  = fld_has_q;
		fld_ovf_n  = fld_ovf_q;
		fld_upd    = 1'b0;
		if (!fld_stop_q) begin
			if (!step.is_digit) begin
				fld_stop_n = 1'b1;
			end else begin
				fld_has_n = 1'b1;
				if (!fld_ovf_q) begin
					if (step.ovf) begin
						fld_ovf_n = 1'b1;
					end else begin
						fld_upd = 1'b1;
					end
				end
			end
		end
	end

	// parse state transition for the accepted byte
	logic clr_fld, keep_fld;
	always_comb begin
		phase_n  = phase_q;
		skip_n   = skip_q;
		x_n      = x_q;
		y_n      = y_q;
		ys_n     = ys_q;
		color_n  = color_q;
		clr_fld  = 1'b0;
		keep_fld = 1'b1;
		emit     = 1'b0;
		if (in_fire) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (s_axis_tdata == pcsp_pkg::CH_H || s_axis_tdata == pcsp_pkg::CH_S) begin
						phase_n = PH_SKIP;
						skip_n  = pcsp_pkg::SKIP_HS;
					end else if (s_axis_tdata == pcsp_pkg::CH_P) begin
						phase_n = PH_PREFIX;
						skip_n  = pcsp_pkg::SKIP_P;
					end else begin
						phase_n = PH_DISCARD;
					end
				end
				PH_SKIP, PH_PREFIX: begin
					skip_n = skip_dec;
					if (skip_dec == 3'd0) begin
						if (phase_q == PH_PREFIX) begin
							phase_n = PH_X;
							x_n     = '0;
							clr_fld = 1'b1;
						end else begin
							phase_n = PH_IDLE;
						end
					end
				end
				PH_DISCARD: begin
					if (s_axis_tdata == pcsp_pkg::CH_NL) phase_n = PH_IDLE;
				end
				PH_X: begin
					if (s_axis_tdata == pcsp_pkg::CH_NL) begin
						phase_n = PH_IDLE;
					end else if (s_axis_tdata == pcsp_pkg::CH_SP) begin
						if (fld_good) begin
							phase_n = PH_Y;
							y_n     = '0;
							ys_n    = '0;
							clr_fld = 1'b1;
						end else begin
							phase_n = PH_DISCARD;
						end
					end else begin
						keep_fld = 1'b0;
						if (fld_upd) x_n = step.value;
					end
				end
				PH_Y: begin
					if (s_axis_tdata == pcsp_pkg::CH_NL) begin
						phase_n = PH_IDLE;
					end else if (s_axis_tdata == pcsp_pkg::CH_SP) begin
						// range check happens before any colour digit is seen
						if (fld_good && idx_sum < canvas_ext) begin
							phase_n = PH_COLOR;
							color_n = '0;
							clr_fld = 1'b1;
						end else begin
							phase_n = PH_DISCARD;
						end
					end else begin
						keep_fld = 1'b0;
						if (fld_upd) begin
							y_n  = step.value;
							ys_n = ys_step;
						end
					end
				end
				PH_COLOR: begin
					if (s_axis_tdata == pcsp_pkg::CH_NL) begin
						phase_n = PH_IDLE;
						emit    = fld_good;
					end else begin
						keep_fld = 1'b0;
						if (fld_upd) color_n = step.value;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			skip_q     <= '0;
			x_q        <= '0;
			y_q        <= '0;
			ys_q       <= '0;
			color_q    <= '0;
			fld_has_q  <= 1'b0;
			fld_stop_q <= 1'b0;
			fld_ovf_q  <= 1'b0;
			canvas_q   <= pcsp_pkg::CANVAS_RESET;
		end else begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			x_q     <= x_n;
			y_q     <= y_n;
			ys_q    <= ys_n;
			color_q <= color_n;
			if (clr_fld) begin
				fld_has_q  <= 1'b0;
				fld_stop_q <= 1'b0;
				fld_ovf_q  <= 1'b0;
			end else if (!keep_fld) begin
				fld_has_q  <= fld_has_n;
				fld_stop_q <= fld_stop_n;
				fld_ovf_q  <= fld_ovf_n;
			end
			if (cfg_wr_en) canvas_q <= cfg_wr_data;
		end
	end

	// result: index low word, colour byte-reversed in the high word
	assign result = {pcsp_pkg::swap_bytes(color_q), idx_sum[pcsp_pkg::VAL_W-1:0]};
	assign push   = emit;
	assign pop    = out_valid_q && m_axis_tready;

	// output register plus one skid entry; input held off only when skid is full
	assign s_axis_tready = !skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_data_q <= skid_valid_q ? skid_data_q : result;
		end else if (push) begin
			skid_data_q <= result;
		end
	end

	// skid entry is only ever filled behind a waiting output transfer
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output entry");

	// a write only comes from a newline ending a colour field
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (phase_q == PH_COLOR && s_axis_tdata == pcsp_pkg::CH_NL))
		else $error("pixel write outside colour phase");

	a_skip_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != 3'd0 && skip_q <= pcsp_pkg::SKIP_HS))
		else $error("skip count out of range");

	a_prefix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PREFIX) |-> (skip_q == pcsp_pkg::SKIP_ONE || skip_q == pcsp_pkg::SKIP_P))
		else $error("prefix skip count out of range");

	// entering the colour field starts from a clean accumulator
	a_color_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_Y && phase_n == PH_COLOR)
		|=> (color_q == '0 && !fld_has_q && !fld_ovf_q && !fld_stop_q))
		else $error("colour field not cleared on entry");

endmodule
